[rtl/tqsc_pkg.sv]
// tqsc_pkg: shared widths, payload structs and register indexes for the
// textured quad scissor clip core. no dependencies.
package tqsc_pkg;

  localparam int COORD_W  = 24;
  localparam int TEX_W    = 16;
  localparam int COLOUR_W = 32;
  localparam int NUM_W    = COORD_W + TEX_W;
  localparam int LANES    = 4;
  localparam int INDEX_W  = 3;

  localparam logic signed [COORD_W-1:0] COORD_MAXPOS = {1'b0, {(COORD_W-1){1'b1}}};

  typedef enum logic [INDEX_W-1:0] {
    REG_CLIP_ENABLE = 3'd0,
    REG_CLIP_LEFT   = 3'd1,
    REG_CLIP_TOP    = 3'd2,
    REG_CLIP_RIGHT  = 3'd3,
    REG_CLIP_BOTTOM = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_x;
    logic signed [COORD_W-1:0] top_y;
    logic signed [COORD_W-1:0] right_x;
    logic signed [COORD_W-1:0] bottom_y;
    logic [TEX_W-1:0]          tex_u_left;
    logic [TEX_W-1:0]          tex_v_top;
    logic [TEX_W-1:0]          tex_u_right;
    logic [TEX_W-1:0]          tex_v_bottom;
    logic [COLOUR_W-1:0]       colour_in;
  } quad_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_left_x;
    logic signed [COORD_W-1:0] out_top_y;
    logic signed [COORD_W-1:0] out_right_x;
    logic signed [COORD_W-1:0] out_bottom_y;
    logic [TEX_W-1:0]          out_u_left;
    logic [TEX_W-1:0]          out_v_top;
    logic [TEX_W-1:0]          out_u_right;
    logic [TEX_W-1:0]          out_v_bottom;
    logic [COLOUR_W-1:0]       colour_out;
  } quad_out_t;

endpackage

[rtl/textured_quad_scissor_clip_core.sv]
// path: stage 1 to stage 3, then the divider stages, then the output register
// throughput: one quad per cycle; a rejected quad leaves a bubble and gives no output
// the whole pipeline advances together and holds while the output beat is stalled
// the four texture divisions use four pipelined dividers, one quotient bit per stage
// reset (synchronous, rst high) clears all valid bits and loads the clip registers
// with clipping off and the rectangle spanning the positive quadrant
module textured_quad_scissor_clip_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  tqsc_pkg::quad_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output tqsc_pkg::quad_out_t               out_data,
  input  logic                              wr_en,
  input  logic [tqsc_pkg::INDEX_W-1:0]      wr_index,
  input  logic [tqsc_pkg::COORD_W-1:0]      wr_data
);

  localparam int CW = tqsc_pkg::COORD_W;
  localparam int TW = tqsc_pkg::TEX_W;
  localparam int NW = tqsc_pkg::NUM_W;
  localparam int NL = tqsc_pkg::LANES;

  typedef struct packed {
    logic [TW-1:0] t0;
    logic          up;
    logic          keep;
  } lane_side_t;

  typedef struct packed {
    logic signed [CW-1:0]            x0;
    logic signed [CW-1:0]            y0;
    logic signed [CW-1:0]            x1;
    logic signed [CW-1:0]            y1;
    logic [tqsc_pkg::COLOUR_W-1:0]   colour;
    lane_side_t [NL-1:0]             lane;
  } side_t;

  // clip registers
  logic                 clip_enable;
  logic signed [CW-1:0] clip_left, clip_top, clip_right, clip_bottom;

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_enable <= 1'b0;
      clip_left   <= '0;
      clip_top    <= '0;
      clip_right  <= tqsc_pkg::COORD_MAXPOS;
      clip_bottom <= tqsc_pkg::COORD_MAXPOS;
    end else if (wr_en) begin
      unique case (wr_index)
        tqsc_pkg::REG_CLIP_ENABLE: clip_enable <= wr_data[0];
        tqsc_pkg::REG_CLIP_LEFT:   clip_left   <= wr_data;
        tqsc_pkg::REG_CLIP_TOP:    clip_top    <= wr_data;
        tqsc_pkg::REG_CLIP_RIGHT:  clip_right  <= wr_data;
        tqsc_pkg::REG_CLIP_BOTTOM: clip_bottom <= wr_data;
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: reject, clamp, extents and texture deltas
  logic                 x_flat, y_flat, reject;
  logic signed [CW:0]   dx, dy;
  logic signed [CW-1:0] nx0, nx1, ny0, ny1;
  logic [CW:0]          k0x, k1x, k0y, k1y;
  logic [TW-1:0]        du, dv;
  logic                 u_up, v_up;
  logic [TW-1:0]        u_far, v_far;
  side_t                s1_side_next;
  logic [CW-1:0]        ud_next [NL];
  logic [CW-1:0]        uk_next [NL];
  logic [TW-1:0]        diff_next [NL];

  always_comb begin
    dx     = {in_data.right_x[CW-1], in_data.right_x} - {in_data.left_x[CW-1], in_data.left_x};
    dy     = {in_data.bottom_y[CW-1], in_data.bottom_y} - {in_data.top_y[CW-1], in_data.top_y};
    x_flat = dx[CW] || (dx == '0);
    y_flat = dy[CW] || (dy == '0);
    reject = clip_enable && (in_data.right_x <= clip_left || in_data.left_x >= clip_right ||
                             in_data.bottom_y <= clip_top || in_data.top_y >= clip_bottom);
    nx0 = (in_data.left_x < clip_left) ? clip_left : in_data.left_x;
    nx1 = (in_data.right_x > clip_right) ? clip_right : in_data.right_x;
    ny0 = (in_data.top_y < clip_top) ? clip_top : in_data.top_y;
    ny1 = (in_data.bottom_y > clip_bottom) ? clip_bottom : in_data.bottom_y;
    k0x = {nx0[CW-1], nx0} - {in_data.left_x[CW-1], in_data.left_x};
    k1x = {nx1[CW-1], nx1} - {in_data.left_x[CW-1], in_data.left_x};
    k0y = {ny0[CW-1], ny0} - {in_data.top_y[CW-1], in_data.top_y};
    k1y = {ny1[CW-1], ny1} - {in_data.top_y[CW-1], in_data.top_y};
    u_up = in_data.tex_u_right >= in_data.tex_u_left;
    v_up = in_data.tex_v_bottom >= in_data.tex_v_top;
    du   = u_up ? in_data.tex_u_right - in_data.tex_u_left
                : in_data.tex_u_left - in_data.tex_u_right;
    dv   = v_up ? in_data.tex_v_bottom - in_data.tex_v_top
                : in_data.tex_v_top - in_data.tex_v_bottom;
    // far edges pass their own coordinate only when clipping is off
    u_far = clip_enable ? in_data.tex_u_left : in_data.tex_u_right;
    v_far = clip_enable ? in_data.tex_v_top : in_data.tex_v_bottom;

    s1_side_next.x0     = clip_enable ? nx0 : in_data.left_x;
    s1_side_next.y0     = clip_enable ? ny0 : in_data.top_y;
    s1_side_next.x1     = clip_enable ? nx1 : in_data.right_x;
    s1_side_next.y1     = clip_enable ? ny1 : in_data.bottom_y;
    s1_side_next.colour = in_data.colour_in;
    // lane order: u left, u right, v top, v bottom
    s1_side_next.lane[0] = '{t0: in_data.tex_u_left, up: u_up, keep: !clip_enable || x_flat};
    s1_side_next.lane[1] = '{t0: u_far,              up: u_up, keep: !clip_enable || x_flat};
    s1_side_next.lane[2] = '{t0: in_data.tex_v_top,  up: v_up, keep: !clip_enable || y_flat};
    s1_side_next.lane[3] = '{t0: v_far,              up: v_up, keep: !clip_enable || y_flat};
    ud_next[0] = dx[CW-1:0];  uk_next[0] = k0x[CW-1:0]; diff_next[0] = du;
    ud_next[1] = dx[CW-1:0];  uk_next[1] = k1x[CW-1:0]; diff_next[1] = du;
    ud_next[2] = dy[CW-1:0];  uk_next[2] = k0y[CW-1:0]; diff_next[2] = dv;
    ud_next[3] = dy[CW-1:0];  uk_next[3] = k1y[CW-1:0]; diff_next[3] = dv;
  end

  logic          s1_valid, s2_valid, s3_valid;
  side_t         s1_side, s2_side, s3_side;
  logic [CW-1:0] s1_ud [NL];
  logic [CW-1:0] s1_uk [NL];
  logic [TW-1:0] s1_diff [NL];
  logic [NW-1:0] s2_prod [NL];
  logic [CW-1:0] s2_ud [NL];
  logic [NW-1:0] s3_num [NL];
  logic [CW-1:0] s3_ud [NL];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid && !reject;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_side <= s1_side_next;
      s2_side <= s1_side;
      s3_side <= s2_side;
      for (int l = 0; l < NL; l++) begin
        s1_ud[l]   <= ud_next[l];
        s1_uk[l]   <= uk_next[l];
        s1_diff[l] <= diff_next[l];
        // stage 2: product of clamped offset and texture delta
        s2_prod[l] <= s1_uk[l] * s1_diff[l];
        s2_ud[l]   <= s1_ud[l];
        // stage 3: add half the extent for round to nearest
        s3_num[l]  <= s2_prod[l] + NW'(s2_ud[l] >> 1);
        s3_ud[l]   <= s2_ud[l];
      end
    end
  end

  logic [TW-1:0] quo [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    tqsc_div u_div (
      .clk (clk),
      .en  (adv),
      .num (s3_num[l]),
      .den (s3_ud[l]),
      .quo (quo[l])
    );
  end

  // side data rides alongside the divider stages
  logic  dv_valid [TW];
  side_t dv_side  [TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < TW; s++) dv_valid[s] <= 1'b0;
    end else if (adv) begin
      dv_valid[0] <= s3_valid;
      for (int s = 1; s < TW; s++) dv_valid[s] <= dv_valid[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_side[0] <= s3_side;
      for (int s = 1; s < TW; s++) dv_side[s] <= dv_side[s-1];
    end
  end

  logic [TW-1:0] tex_res [NL];
  side_t         fin;

  always_comb begin
    fin = dv_side[TW-1];
    for (int l = 0; l < NL; l++) begin
      if (fin.lane[l].keep) begin
        tex_res[l] = fin.lane[l].t0;
      end else if (fin.lane[l].up) begin
        tex_res[l] = fin.lane[l].t0 + quo[l];
      end else begin
        tex_res[l] = fin.lane[l].t0 - quo[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_valid[TW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.out_left_x   <= fin.x0;
      out_data.out_top_y    <= fin.y0;
      out_data.out_right_x  <= fin.x1;
      out_data.out_bottom_y <= fin.y1;
      out_data.out_u_left   <= tex_res[0];
      out_data.out_u_right  <= tex_res[1];
      out_data.out_v_top    <= tex_res[2];
      out_data.out_v_bottom <= tex_res[3];
      out_data.colour_out   <= fin.colour;
    end
  end

`ifndef SYNTHESIS
  // a stalled output beat freezes the whole pipe
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(s3_valid) && $stable(dv_valid[TW-1]))
    else $error("pipeline moved while output stalled");

  // upward remap of the u left lane never wraps the texture field
  a_no_wrap_up: assert property (@(posedge clk) disable iff (rst)
    dv_valid[TW-1] && !fin.lane[0].keep && fin.lane[0].up |->
      ({1'b0, fin.lane[0].t0} + {1'b0, quo[0]}) <= {1'b0, {TW{1'b1}}})
    else $error("u left remap overflow");

  // downward remap of the v bottom lane never goes below zero
  a_no_wrap_down: assert property (@(posedge clk) disable iff (rst)
    dv_valid[TW-1] && !fin.lane[3].keep && !fin.lane[3].up |->
      quo[3] <= fin.lane[3].t0)
    else $error("v bottom remap underflow");
`endif

endmodule

[rtl/tqsc_div.sv]
// tqsc_div: pipelined restoring divider, one quotient bit per stage.
// the quotient must fit TEX_W bits (num < den << TEX_W). uses tqsc_pkg.
module tqsc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [tqsc_pkg::NUM_W-1:0]    num,
  input  logic [tqsc_pkg::COORD_W-1:0]  den,
  output logic [tqsc_pkg::TEX_W-1:0]    quo
);

  localparam int CW = tqsc_pkg::COORD_W;
  localparam int TW = tqsc_pkg::TEX_W;

  logic [CW-1:0] rem_q  [0:TW];
  logic [TW-1:0] low_q  [0:TW];
  logic [CW-1:0] den_q  [0:TW];
  logic [TW-1:0] quo_q  [0:TW];

  // stage zero is the unregistered input
  assign rem_q[0] = num[tqsc_pkg::NUM_W-1:TW];
  assign low_q[0] = num[TW-1:0];
  assign den_q[0] = den;
  assign quo_q[0] = '0;

  for (genvar s = 0; s < TW; s++) begin : g_step
    logic [CW:0]   trial;
    logic          ge;
    logic [CW:0]   diff;

    always_comb begin
      trial = {rem_q[s], low_q[s][TW-1]};
      ge    = trial >= {1'b0, den_q[s]};
      diff  = trial - {1'b0, den_q[s]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s+1] <= ge ? diff[CW-1:0] : trial[CW-1:0];
        low_q[s+1] <= {low_q[s][TW-2:0], 1'b0};
        den_q[s+1] <= den_q[s];
        quo_q[s+1] <= {quo_q[s][TW-2:0], ge};
      end
    end
  end

  assign quo = quo_q[TW];

endmodule
